// ===== hw/rtl/ffsc_pkg.sv =====
// Shared types and constants for the furthest-from-focus slot cache.
// Holds op and status codes, port widths, controller states and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package ffsc_pkg;

  // Fixed port widths
  localparam int OP_W     = 2;
  localparam int ITEM_W   = 12;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int CFG_W    = 7;

  // Reset value of the slots-in-use register
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PLACED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd4;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture request, clear scan trackers
    logic issue;   // read next slot
    logic finish;  // commit table update and drive result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_issue;  // slot being read is the last one in use
  } sts_t;

endpackage

// ===== hw/rtl/ffsc_ctrl.sv =====
// Controller state machine for the slot cache: sequences load, scan and commit.
// Depends on ffsc_pkg for state_t, cmd_t and sts_t.
`timescale 1ns / 1ps

module ffsc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output ffsc_pkg::cmd_t cmd,
  input  ffsc_pkg::sts_t sts
);

  ffsc_pkg::state_t state_r;
  ffsc_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffsc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state_r)
      ffsc_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ffsc_pkg::S_SCAN;
        end
      end
      ffsc_pkg::S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) begin
          state_nxt = ffsc_pkg::S_WAIT;
        end
      end
      ffsc_pkg::S_WAIT: begin
        // last read slot is compared in this cycle
        state_nxt = ffsc_pkg::S_DONE;
      end
      ffsc_pkg::S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ffsc_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ffsc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ffsc_dpath.sv =====
// Datapath for the slot cache: slot memory, full flags, scan trackers and result registers.
// Depends on ffsc_pkg for codes, widths and the command/status structs.
`timescale 1ns / 1ps

module ffsc_dpath #(
  parameter int SLOTS     = 64,
  parameter int ITEM_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ffsc_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic [ffsc_pkg::OP_W-1:0]       in_op,
  input  logic [ffsc_pkg::ITEM_W-1:0]     in_item,
  input  logic [ffsc_pkg::ITEM_W-1:0]     in_focus,
  input  ffsc_pkg::cmd_t                  cmd,
  output ffsc_pkg::sts_t                  sts,
  output logic                            out_valid,
  output logic [ffsc_pkg::STATUS_W-1:0]   out_status,
  output logic [ffsc_pkg::SLOT_W-1:0]     out_slot,
  output logic                            out_evicted_valid,
  output logic [ffsc_pkg::ITEM_W-1:0]     out_evicted_item
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Configuration and captured request
  logic [ffsc_pkg::CFG_W-1:0] cfg_r;
  logic [ffsc_pkg::OP_W-1:0]  op_r;
  logic [ITEM_BITS-1:0]       item_r;
  logic [ITEM_BITS-1:0]       focus_r;
  logic [IDX_W-1:0]           last_idx_r;

  // Scan pipeline
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 cmp_vld_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic [ITEM_BITS-1:0] rd_data_r;

  // Scan trackers
  logic                 hit_vld_r;
  logic [IDX_W-1:0]     hit_idx_r;
  logic                 emp_vld_r;
  logic [IDX_W-1:0]     emp_idx_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [ITEM_BITS-1:0] best_dist_r;
  logic [ITEM_BITS-1:0] best_item_r;

  // Table storage
  logic [ITEM_BITS-1:0] mem [SLOTS];
  logic [SLOTS-1:0]     full_r;
  logic [SLOTS-1:0]     full_nxt;

  // Result registers
  logic                          out_valid_r;
  logic [ffsc_pkg::STATUS_W-1:0] out_status_r;
  logic [ffsc_pkg::SLOT_W-1:0]   out_slot_r;
  logic                          out_ev_vld_r;
  logic [ffsc_pkg::ITEM_W-1:0]   out_ev_item_r;

  // Combinational helpers
  logic [ITEM_BITS+ffsc_pkg::ITEM_W-1:0] item_ext;
  logic [ITEM_BITS+ffsc_pkg::ITEM_W-1:0] focus_ext;
  logic [8:0]                            n_w;
  logic                                  cmp_full;
  logic [ITEM_BITS-1:0]                  cand_dist;
  logic                                  mem_we;
  logic [IDX_W-1:0]                      mem_waddr;
  logic [ffsc_pkg::STATUS_W-1:0]         fin_status;
  logic [IDX_W-1:0]                      fin_idx;
  logic                                  fin_ev_vld;
  logic [IDX_W+ffsc_pkg::SLOT_W-1:0]     slot_ext;
  logic [ITEM_BITS+ffsc_pkg::ITEM_W-1:0] ev_ext;

  // Fit port fields to the stored item width
  assign item_ext  = {{ITEM_BITS{1'b0}}, in_item};
  assign focus_ext = {{ITEM_BITS{1'b0}}, in_focus};

  // Clamp slots in use to 1..SLOTS
  always_comb begin
    if (cfg_r == '0) begin
      n_w = 9'd1;
    end else if (int'(cfg_r) > SLOTS) begin
      n_w = 9'(SLOTS);
    end else begin
      n_w = {2'b00, cfg_r};
    end
  end

  assign sts.last_issue = (rd_idx_r == last_idx_r);

  // Compare stage: absolute distance of the read item to the focus
  assign cmp_full  = full_r[cmp_idx_r];
  assign cand_dist = (rd_data_r > focus_r) ? (rd_data_r - focus_r)
                                           : (focus_r - rd_data_r);

  // Commit decision
  always_comb begin
    fin_status = ffsc_pkg::ST_MISSING;
    fin_idx    = '0;
    fin_ev_vld = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = emp_idx_r;
    full_nxt   = full_r;
    unique case (op_r)
      ffsc_pkg::OP_INSERT: begin
        if (hit_vld_r) begin
          fin_status = ffsc_pkg::ST_PRESENT;
          fin_idx    = hit_idx_r;
        end else if (emp_vld_r) begin
          fin_status = ffsc_pkg::ST_PLACED;
          fin_idx    = emp_idx_r;
          mem_we     = cmd.finish;
          mem_waddr  = emp_idx_r;
          full_nxt[emp_idx_r] = 1'b1;
        end else begin
          fin_status = ffsc_pkg::ST_REPLACED;
          fin_idx    = best_idx_r;
          fin_ev_vld = 1'b1;
          mem_we     = cmd.finish;
          mem_waddr  = best_idx_r;
        end
      end
      ffsc_pkg::OP_RELEASE: begin
        if (hit_vld_r) begin
          fin_status = ffsc_pkg::ST_FOUND;
          fin_idx    = hit_idx_r;
          full_nxt[hit_idx_r] = 1'b0;
        end
      end
      ffsc_pkg::OP_LOOKUP: begin
        if (hit_vld_r) begin
          fin_status = ffsc_pkg::ST_FOUND;
          fin_idx    = hit_idx_r;
        end
      end
      default: begin
        fin_status = ffsc_pkg::ST_MISSING;
      end
    endcase
  end

  assign slot_ext = {{ffsc_pkg::SLOT_W{1'b0}}, fin_idx};
  assign ev_ext   = {{ffsc_pkg::ITEM_W{1'b0}}, best_item_r};

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ffsc_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // Slot memory: one read per scan cycle, one write at commit
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= item_r;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  // Full flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= '0;
    end else if (cmd.finish) begin
      full_r <= full_nxt;
    end
  end

  // Request capture, read address and compare pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.issue;
    end
    if (cmd.load) begin
      op_r       <= in_op;
      item_r     <= item_ext[ITEM_BITS-1:0];
      focus_r    <= focus_ext[ITEM_BITS-1:0];
      last_idx_r <= IDX_W'(n_w - 9'd1);
      rd_idx_r   <= '0;
    end else if (cmd.issue) begin
      rd_idx_r <= IDX_W'(rd_idx_r + 1'b1);
    end
    if (cmd.issue) begin
      cmp_idx_r <= rd_idx_r;
    end
  end

  // Scan trackers: highest hit, lowest empty, first furthest full slot
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_vld_r   <= 1'b0;
      hit_idx_r   <= '0;
      emp_vld_r   <= 1'b0;
      emp_idx_r   <= '0;
      best_idx_r  <= '0;
      best_dist_r <= '0;
      best_item_r <= '0;
    end else if (cmp_vld_r) begin
      if (cmp_full && (rd_data_r == item_r)) begin
        hit_vld_r <= 1'b1;
        hit_idx_r <= cmp_idx_r;
      end
      if (!cmp_full && !emp_vld_r) begin
        emp_vld_r <= 1'b1;
        emp_idx_r <= cmp_idx_r;
      end
      if (cmp_full && (cand_dist > best_dist_r)) begin
        best_dist_r <= cand_dist;
        best_idx_r  <= cmp_idx_r;
      end
      // slot 0 is the fallback victim when all distances are zero
      if (cmp_full && ((cand_dist > best_dist_r) || (cmp_idx_r == '0))) begin
        best_item_r <= rd_data_r;
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
    if (cmd.finish) begin
      out_status_r  <= fin_status;
      out_slot_r    <= slot_ext[ffsc_pkg::SLOT_W-1:0];
      out_ev_vld_r  <= fin_ev_vld;
      out_ev_item_r <= fin_ev_vld ? ev_ext[ffsc_pkg::ITEM_W-1:0] : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_evicted_valid = out_ev_vld_r;
  assign out_evicted_item  = out_ev_item_r;

endmodule

// ===== hw/rtl/furthest_from_focus_slot_cache.sv =====
// Top level of the furthest-from-focus slot cache: controller plus datapath.
// Depends on ffsc_pkg, ffsc_ctrl and ffsc_dpath.
//
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+--------------------------
//  request   | in_op, in_item, in_focus                      | start && !busy
//  result    | out_status, out_slot, out_evicted_valid/_item | out_valid, one cycle
//  config    | cfg_wdata                                     | cfg_we
//
// A request scans n slots, n being the clamped slots-in-use count: the
// single slot memory is read one slot a cycle in S_SCAN, then a compare
// state (S_WAIT) and a commit state (S_DONE) follow before the strobe.
// The next request can transfer in the cycle the result strobe is shown.
// Reset (rst_n low, synchronous) empties every slot and sets slots in use to 64.
// The result receiver cannot stall; results are never held back.
`timescale 1ns / 1ps

module furthest_from_focus_slot_cache #(
  parameter int SLOTS     = 64,
  parameter int ITEM_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ffsc_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic [ffsc_pkg::OP_W-1:0]     in_op,
  input  logic [ffsc_pkg::ITEM_W-1:0]   in_item,
  input  logic [ffsc_pkg::ITEM_W-1:0]   in_focus,
  output logic                          out_valid,
  output logic [ffsc_pkg::STATUS_W-1:0] out_status,
  output logic [ffsc_pkg::SLOT_W-1:0]   out_slot,
  output logic                          out_evicted_valid,
  output logic [ffsc_pkg::ITEM_W-1:0]   out_evicted_item
);

  ffsc_pkg::cmd_t cmd;
  ffsc_pkg::sts_t sts;

  // Sequencer
  ffsc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Table and scan logic
  ffsc_dpath #(
    .SLOTS     (SLOTS),
    .ITEM_BITS (ITEM_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_op             (in_op),
    .in_item           (in_item),
    .in_focus          (in_focus),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_item  (out_evicted_item)
  );

endmodule

// ===== hw/rtl/ffsc_checker.sv =====
// Port-level checks for the slot cache, attached to the top level by bind.
// Depends on ffsc_pkg for status codes and port widths.
`timescale 1ns / 1ps

module ffsc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [ffsc_pkg::STATUS_W-1:0] out_status,
  input logic                          out_evicted_valid,
  input logic [ffsc_pkg::ITEM_W-1:0]   out_evicted_item
);

  // A request transfer starts work
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after request transfer");

  // Finishing work shows exactly one result strobe, outside busy
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> (out_valid && !busy))
    else $error("no result strobe when work finished");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // Eviction is reported only with a replace status, else the item is zero
  a_evict_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_evicted_valid == (out_status == ffsc_pkg::ST_REPLACED)) &&
                   (out_evicted_valid || (out_evicted_item == '0))))
    else $error("eviction fields inconsistent with status");

endmodule

bind furthest_from_focus_slot_cache ffsc_checker u_ffsc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_evicted_valid (out_evicted_valid),
  .out_evicted_item  (out_evicted_item)
);
